// ----- rtl/core/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg: shared types and helpers for the sorted timer queue
// Request and result codes, the cell entry and control words, and the
// saturating time adder.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned TimeW        = 48;
  localparam int unsigned HandleW      = 32;
  localparam int unsigned DelayW       = 32;
  localparam int unsigned QueueDepthDef = 16;
  localparam logic [31:0] IdleWaitRst  = 32'd6000000;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_POLL     = 2'd1,
    REQ_TICK     = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    RES_REGISTERED = 3'd0,
    RES_REJECTED   = 3'd1,
    RES_DUE        = 3'd2,
    RES_DEADLINE   = 3'd3,
    RES_TICK_DONE  = 3'd4
  } res_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic               valid;
    logic [TimeW-1:0]   deadline;
    logic [HandleW-1:0] action;
  } entry_t;

  typedef struct packed {
    cell_op_e           op;
    logic [TimeW-1:0]   target;
    logic [HandleW-1:0] handle;
  } cell_ctrl_t;

  // base + add, clamped at the top of the time range
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] base,
                                               input logic [DelayW-1:0] add);
    logic [TimeW:0] sum;
    sum = {1'b0, base} + {{(TimeW+1-DelayW){1'b0}}, add};
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

endpackage

// ----- rtl/core/stq_cell.sv -----
// ----------------------------------------------------------------------------
// stq_cell: one slot of the deadline-ordered chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbour's entry; on pop it takes its right neighbour's entry.
// ----------------------------------------------------------------------------
module stq_cell
  import stq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_i,
  input  logic       left_le_i,
  input  entry_t     right_i,
  output entry_t     entry_o,
  output logic       le_o
);

  entry_t entry_q, entry_d;

  // entry at or before the insert target stays put, keeping ties in order
  assign le_o = entry_q.valid && (entry_q.deadline <= ctrl_i.target);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (!le_o) begin
          if (left_le_i) begin
            entry_d = '{valid: 1'b1, deadline: ctrl_i.target, action: ctrl_i.handle};
          end else begin
            entry_d = left_i;
          end
        end
      end
      CELL_POP: entry_d = right_i;
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/core/sorted_timer_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit: deadline-ordered timer queue
// A chain of cells holds the pending actions sorted by deadline.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_type_i, delay_us_i, action_handle_i and pulse
//   start; the word is taken on a rising edge with start high and busy low.
//   busy stays low, so a new word may be taken on every cycle.
//   Result channel: one word per register, poll or tick request, shown for
//   one cycle with result_valid_o high, in the cycle after the request is taken.
//   The receiver cannot stall; results are never held back.
//   Throughput is one request per cycle: every cell compares its deadline
//   with the insert target in parallel and shifts in the same cycle, so the
//   critical path is the 48-bit target add followed by the cell compare.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_data_i writing the
//   idle wait; ready is always high. Write it only while the queue is idle.
//   Reset empties the queue, zeroes the time counter and sets the idle wait
//   to 6000000 us. A request code of 3 is taken and gives no result.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit
  import stq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [DelayW-1:0]  delay_us_i,
  input  logic [HandleW-1:0] action_handle_i,
  output logic               result_valid_o,
  output logic [2:0]         result_kind_o,
  output logic [HandleW-1:0] due_action_o,
  output logic [TimeW-1:0]   deadline_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);

  logic [TimeW-1:0] time_q, time_d;
  logic [31:0]      idle_wait_q;

  logic             res_valid_q, res_valid_d;
  res_e             res_kind_q, res_kind_d;
  logic [HandleW-1:0] res_action_q, res_action_d;
  logic [TimeW-1:0] res_deadline_q, res_deadline_d;

  cell_ctrl_t       ctrl;
  entry_t           cell_entry [QueueDepth];
  logic             cell_le    [QueueDepth];

  logic             accept;
  logic             full;
  logic             head_due;
  entry_t           head;
  entry_t           empty_entry;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  assign head        = cell_entry[0];
  assign full        = cell_entry[QueueDepth-1].valid;
  assign head_due    = head.valid && (head.deadline <= time_q);
  assign empty_entry = '{valid: 1'b0, deadline: '0, action: '0};

  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.target    = sat_add(time_q, delay_us_i);
    ctrl.handle    = action_handle_i;
    time_d         = time_q;
    res_valid_d    = 1'b0;
    res_kind_d     = RES_TICK_DONE;
    res_action_d   = '0;
    res_deadline_d = '0;
    if (accept) begin
      case (req_type_i)
        REQ_REGISTER: begin
          res_valid_d = 1'b1;
          if (full) begin
            res_kind_d = RES_REJECTED;
          end else begin
            ctrl.op    = CELL_INSERT;
            res_kind_d = RES_REGISTERED;
          end
        end
        REQ_POLL: begin
          res_valid_d = 1'b1;
          if (head_due) begin
            ctrl.op      = CELL_POP;
            res_kind_d   = RES_DUE;
            res_action_d = head.action;
          end else begin
            res_kind_d     = RES_DEADLINE;
            res_deadline_d = head.valid ? head.deadline : sat_add(time_q, idle_wait_q);
          end
        end
        REQ_TICK: begin
          res_valid_d = 1'b1;
          res_kind_d  = RES_TICK_DONE;
          time_d      = sat_add(time_q, {{(DelayW-1){1'b0}}, 1'b1});
        end
        default: res_valid_d = 1'b0;
      endcase
    end
  end

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_le;

    if (i == 0) begin : g_first
      assign left_entry = empty_entry;
      assign left_le    = 1'b1;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == QueueDepth - 1) begin : g_last
      assign right_entry = empty_entry;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    stq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_entry),
      .left_le_i (left_le),
      .right_i   (right_entry),
      .entry_o   (cell_entry[i]),
      .le_o      (cell_le[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      idle_wait_q <= IdleWaitRst;
      res_valid_q <= 1'b0;
    end else begin
      time_q      <= time_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        idle_wait_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q     <= res_kind_d;
    res_action_q   <= res_action_d;
    res_deadline_q <= res_deadline_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign due_action_o   = res_action_q;
  assign deadline_o     = res_deadline_q;

endmodule

// ----- verif/sorted_timer_queue_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit_tb: self-checking bench for the deadline-ordered timer queue
// A directed table covers the empty poll, the extremes of delay and handle,
// a full queue, ties and the unused request code. Random phases follow, each
// with its own idle wait. Every word is checked against its pinned table
// expectation where it has one, else against an in-bench scheduler model.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit_tb
  import stq_pkg::*;
();

  localparam int unsigned QUEUE_SLOTS    = QueueDepthDef;
  localparam logic [1:0]  REQ_UNUSED     = 2'd3;
  localparam logic [TimeW-1:0] TIME_MAX  = {TimeW{1'b1}};
  localparam int          PHASES         = 6;
  localparam int          PHASE_ITEMS    = 317;
  localparam int          CALM_PHASE     = 2;
  localparam int          TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    res_e               kind;
    logic [HandleW-1:0] act;
    logic [TimeW-1:0]   dl;
  } timer_result_t;

  typedef struct {
    logic [1:0]         req;
    logic [DelayW-1:0]  delay;
    logic [HandleW-1:0] handle;
    int                 reps;
    bit                 pinned;
    timer_result_t      want;
  } stim_row_t;

  localparam timer_result_t NO_PIN = '0;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic [1:0]         req_type_i      = '0;
  logic [DelayW-1:0]  delay_us_i      = '0;
  logic [HandleW-1:0] action_handle_i = '0;
  logic               result_valid_o;
  logic [2:0]         result_kind_o;
  logic [HandleW-1:0] due_action_o;
  logic [TimeW-1:0]   deadline_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [31:0]        cfg_data_i      = '0;

  // typed expectation travelling with the word, overrides the model's
  bit                 pin_valid = 1'b0;
  timer_result_t      pin_value = '0;

  // scheduler model state
  logic [TimeW-1:0]   sched_deadline[$];
  logic [HandleW-1:0] sched_action[$];
  logic [TimeW-1:0]   now_us    = '0;
  logic [31:0]        idle_wait = IdleWaitRst;

  timer_result_t      pending_results[$];
  int                 mismatch_count = 0;
  int                 checked_count  = 0;
  int                 taken_count    = 0;
  int                 due_seen       = 0;
  int                 rejected_seen  = 0;
  int                 deadline_seen  = 0;
  int                 peak_depth     = 0;

  sorted_timer_queue_unit #(
    .QueueDepth(QUEUE_SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .delay_us_i     (delay_us_i),
    .action_handle_i(action_handle_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .due_action_o   (due_action_o),
    .deadline_o     (deadline_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [TimeW-1:0] clamp_add(input logic [TimeW-1:0] base,
                                                 input logic [31:0] amount);
    logic [TimeW:0] total;
    total = {1'b0, base} + {{(TimeW+1-32){1'b0}}, amount};
    if (total > {1'b0, TIME_MAX}) return TIME_MAX;
    return total[TimeW-1:0];
  endfunction

  // entries that will not fall due within a few hundred ticks
  function automatic int far_entries();
    int n;
    n = 0;
    foreach (sched_deadline[i])
      if (sched_deadline[i] > clamp_add(now_us, 32'd300)) n++;
    return n;
  endfunction

  // apply one request to the scheduler model; 0 when no word results
  function automatic bit schedule_request(input logic [1:0] req,
                                          input logic [DelayW-1:0] delay,
                                          input logic [HandleW-1:0] handle,
                                          output timer_result_t res);
    logic [TimeW-1:0] target;
    int slot;
    res = NO_PIN;
    case (req)
      REQ_REGISTER: begin
        if (sched_deadline.size() >= QUEUE_SLOTS) begin
          res.kind = RES_REJECTED;
        end else begin
          target = clamp_add(now_us, delay);
          slot = 0;
          // ties go behind existing entries
          while (slot < sched_deadline.size() && sched_deadline[slot] <= target) slot++;
          sched_deadline.insert(slot, target);
          sched_action.insert(slot, handle);
          if (sched_deadline.size() > peak_depth) peak_depth = sched_deadline.size();
          res.kind = RES_REGISTERED;
        end
      end
      REQ_POLL: begin
        if (sched_deadline.size() > 0 && sched_deadline[0] <= now_us) begin
          res.kind = RES_DUE;
          res.act = sched_action.pop_front();
          void'(sched_deadline.pop_front());
        end else begin
          res.kind = RES_DEADLINE;
          res.dl = (sched_deadline.size() > 0) ? sched_deadline[0]
                                               : clamp_add(now_us, idle_wait);
        end
      end
      REQ_TICK: begin
        now_us = clamp_add(now_us, 32'd1);
        res.kind = RES_TICK_DONE;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [TimeW-1:0] want,
                                 input logic [TimeW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at word %0d: expected %h, got %h",
               what, checked_count, want, got);
  endtask

  // model update on each taken request, compare on each result word
  always @(posedge clk_i) begin : track_words
    timer_result_t predicted;
    timer_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) idle_wait = cfg_data_i;
      if (start && !busy) begin
        taken_count++;
        if (schedule_request(req_type_i, delay_us_i, action_handle_i, predicted))
          pending_results.push_back(pin_valid ? pin_value : predicted);
      end
      if (result_valid_o) begin
        case (result_kind_o)
          RES_DUE:      due_seen++;
          RES_REJECTED: rejected_seen++;
          RES_DEADLINE: deadline_seen++;
          default: ;
        endcase
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word, kind", '0, TimeW'(result_kind_o));
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (result_kind_o !== want.kind)
            report_mismatch("result_kind", TimeW'(want.kind), TimeW'(result_kind_o));
          if (due_action_o !== want.act)
            report_mismatch("due_action", TimeW'(want.act), TimeW'(due_action_o));
          if (deadline_o !== want.dl)
            report_mismatch("deadline", want.dl, deadline_o);
        end
      end
    end
  end

  task automatic issue_request(input logic [1:0] req, input logic [DelayW-1:0] delay,
                               input logic [HandleW-1:0] handle, input bit pinned,
                               input timer_result_t want);
    start           <= 1'b1;
    req_type_i      <= req;
    delay_us_i      <= delay;
    action_handle_i <= handle;
    pin_valid       <= pinned;
    pin_value       <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_idle_wait(input logic [31:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    // an unused request code leaves no word behind, so allow the pipe to settle
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  stim_row_t directed_rows[18] = '{
    '{REQ_POLL,     32'd0,         32'd0,         1,  1'b1,
      '{RES_DEADLINE, 32'd0, 48'd6000000}},
    '{REQ_TICK,     32'd0,         32'd0,         1,  1'b1, '{RES_TICK_DONE, 32'd0, 48'd0}},
    '{REQ_REGISTER, 32'd0,         32'd0,         1,  1'b1, '{RES_REGISTERED, 32'd0, 48'd0}},
    '{REQ_POLL,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1'b1, '{RES_DUE, 32'd0, 48'd0}},
    '{REQ_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1'b1, '{RES_REGISTERED, 32'd0, 48'd0}},
    '{REQ_POLL,     32'd0,         32'd0,         1,  1'b1,
      '{RES_DEADLINE, 32'd0, 48'h0001_0000_0000}},
    '{REQ_UNUSED,   32'hFFFF_FFFF, 32'h5A5A_A5A5, 1,  1'b0, NO_PIN},
    // fill to the brim with equal deadlines
    '{REQ_REGISTER, 32'd3,         32'h0000_0100, 15, 1'b1, '{RES_REGISTERED, 32'd0, 48'd0}},
    '{REQ_REGISTER, 32'd0,         32'h0000_DEAD, 1,  1'b1, '{RES_REJECTED, 32'd0, 48'd0}},
    '{REQ_POLL,     32'd0,         32'd0,         1,  1'b1, '{RES_DEADLINE, 32'd0, 48'd4}},
    '{REQ_TICK,     32'd0,         32'd0,         3,  1'b1, '{RES_TICK_DONE, 32'd0, 48'd0}},
    '{REQ_POLL,     32'd0,         32'd0,         16, 1'b0, NO_PIN},
    '{REQ_REGISTER, 32'd2,         32'h0000_0200, 1,  1'b1, '{RES_REGISTERED, 32'd0, 48'd0}},
    '{REQ_REGISTER, 32'd2,         32'h0000_0201, 1,  1'b1, '{RES_REGISTERED, 32'd0, 48'd0}},
    '{REQ_REGISTER, 32'd1,         32'h0000_0202, 1,  1'b1, '{RES_REGISTERED, 32'd0, 48'd0}},
    '{REQ_TICK,     32'd0,         32'd0,         2,  1'b1, '{RES_TICK_DONE, 32'd0, 48'd0}},
    '{REQ_POLL,     32'd0,         32'd0,         4,  1'b0, NO_PIN},
    '{REQ_UNUSED,   32'd0,         32'd0,         1,  1'b0, NO_PIN}
  };

  initial begin
    logic [1:0]  req;
    logic [31:0] delay;
    logic [31:0] wait_value;
    int          issued;
    int          profile;
    int          reg_share;
    int          poll_share;
    int          pick;
    int          settle;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[r])
      for (int k = 0; k < directed_rows[r].reps; k++)
        issue_request(directed_rows[r].req, directed_rows[r].delay,
                      directed_rows[r].handle + k, directed_rows[r].pinned,
                      directed_rows[r].want);

    profile = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       wait_value = 32'd0;
        1:       wait_value = 32'hFFFF_FFFF;
        3:       wait_value = 32'd1;
        5:       wait_value = IdleWaitRst;
        default: wait_value = $urandom;
      endcase
      write_idle_wait(wait_value);
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        if (phase != CALM_PHASE)
          while ($urandom_range(0, 99) < 19) begin
            start <= 1'b0;
            @(posedge clk_i);
          end
        // pick at random among filling, draining and a mixed load every 40 items
        if (issued % 40 == 0) profile = $urandom_range(0, 2);
        reg_share  = (profile == 0) ? 60 : (profile == 1) ? 15 : 35;
        poll_share = (profile == 0) ? 20 : (profile == 1) ? 45 : 35;
        pick = $urandom_range(0, 99);
        if (pick < 4)                           req = REQ_UNUSED;
        else if (pick < 4 + reg_share)          req = REQ_REGISTER;
        else if (pick < 4 + reg_share + poll_share) req = REQ_POLL;
        else                                    req = REQ_TICK;
        delay = $urandom;
        if (req == REQ_REGISTER) begin
          pick = $urandom_range(0, 99);
          if (pick < 60)      delay = $urandom_range(0, 8);
          else if (pick < 85) delay = $urandom_range(9, 60);
          // far deadlines never fall due, so keep only a few of them stored
          else if (sched_deadline.size() >= QUEUE_SLOTS || far_entries() < 3)
            delay = (pick < 93) ? $urandom : 32'hFFFF_FFFF;
          else                delay = $urandom_range(0, 8);
        end
        issue_request(req, delay, $urandom, 1'b0, NO_PIN);
        if (req != REQ_UNUSED) issued++;
      end
    end

    start <= 1'b0;
    settle = 0;
    while (pending_results.size() != 0 && settle < 100) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected words never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end
    $display("%0d requests taken over %0d idle-wait settings, %0d words checked",
             taken_count, PHASES + 1, checked_count);
    $display("%0d due pops, %0d full-queue rejections, %0d deadline replies, peak depth %0d",
             due_seen, rejected_seen, deadline_seen, peak_depth);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
